// ===== hdl/aging_history_ring_index_macros.svh =====
// Assertion macros shared by the aging history ring index RTL.
`ifndef AGING_HISTORY_RING_INDEX_MACROS_SVH
`define AGING_HISTORY_RING_INDEX_MACROS_SVH
`ifndef SYNTHESIS
`define AHRI_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");
`define AHRI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define AHRI_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define AHRI_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== hdl/ahri_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package ahri_pkg;

   localparam int OP_W       = 2;
   localparam int STAMP_W    = 32;
   localparam int CNT_W      = 6;
   localparam int ENTRY_W    = 5;
   localparam int SLOT_OUT_W = 5;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 56;

   localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
   localparam logic [OP_W-1:0] OP_READ  = 2'd1;
   localparam logic [OP_W-1:0] OP_SWEEP = 2'd2;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd3;

   localparam logic [1:0] REG_CAPACITY = 2'd0;
   localparam logic [1:0] REG_MAX_AGE  = 2'd1;
   localparam logic [1:0] REG_MARKER   = 2'd2;

   localparam logic [CNT_W-1:0]   CAPACITY_RESET = 6'd32;
   localparam logic [STAMP_W-1:0] MAX_AGE_RESET  = 32'd4233600000;
   localparam logic [STAMP_W-1:0] MARKER_RESET   = 32'd0;

   typedef struct packed {
      logic [ENTRY_W-1:0] entry_number;
      logic [STAMP_W-1:0] now;
   } req_type;

   typedef struct packed {
      logic [CNT_W-1:0]      marked_count;
      logic [CNT_W-1:0]      entry_count;
      logic [STAMP_W-1:0]    entry_age;
      logic [SLOT_OUT_W-1:0] slot_index;
   } rsp_type;

endpackage
`default_nettype wire

// ===== hdl/ahri_rem.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "aging_history_ring_index_macros.svh"
module ahri_rem #(
   parameter int NUM_W = 7,
   parameter int DEN_W = 6
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [DEN_W-1:0] rem
);

   localparam int STEP_W = $clog2(NUM_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [NUM_W-1:0] num_ff, num_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W:0]   trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      trial   = {rem_ff, num_ff[NUM_W-1]};
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         num_in  = num;
         den_in  = den;
         rem_in  = '0;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = DEN_W'(trial - {1'b0, den_ff});
         end else begin
            rem_in = DEN_W'(trial);
         end
         num_in  = num_ff << 1;
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      num_ff  <= num_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
   end

   assign done = done_ff;
   assign rem  = rem_ff;

   `AHRI_ASSERT_IMPLY(a_rem_below_den, clock, reset, done_ff, rem_ff < den_ff)
   `AHRI_ASSERT_IMPLY(a_done_not_busy, clock, reset, done_ff, !busy_ff)

endmodule
`default_nettype wire

// ===== hdl/aging_history_ring_index.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Beat contents
// req_      in         tuser: op; tdata: now, entry_number
// rsp_      out        tuser: status; tdata: slot_index, entry_age, entry_count, marked_count
// csr_      in/out     capacity at 0x0, max_age at 0x4, distant_past_marker at 0x8
//
// Add and clear go from decode straight to the push of a result beat; a read passes an evaluate state first.
// A sweep stays in the evaluate state while it reads entries from the memory, then pushes its result.
// When the start slot lies at or beyond a reduced capacity, the slot lookup runs a
// bit-serial remainder unit, then a memory read state, before the evaluate state.
// Reset is synchronous; it clears the ring pointers and loads the register defaults.
// A stalled result holds in the output register; the next item waits at its push until it moves.
`include "aging_history_ring_index_macros.svh"
module aging_history_ring_index #(
   parameter int DEPTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [31:0] now, [36:32] entry_number, [39:37] zero
   input  logic [ahri_pkg::REQ_DATA_W-1:0]     req_tdata,
   // [1:0] op
   input  logic [ahri_pkg::OP_W-1:0]           req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [4:0] slot_index, [36:5] entry_age, [42:37] entry_count, [48:43] marked_count
   output logic [ahri_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // [0] status
   output logic                                rsp_tuser,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [ahri_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [ahri_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [ahri_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   import ahri_pkg::*;

   localparam int SW    = $clog2(DEPTH);
   localparam int SUM_W = ((SW > CNT_W) ? SW : CNT_W) + 1;
   localparam logic [31:0] DEPTH_L = 32'(DEPTH);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DECODE = 3'd1;
   localparam logic [2:0] ST_DIV    = 3'd2;
   localparam logic [2:0] ST_RD     = 3'd3;
   localparam logic [2:0] ST_EVAL   = 3'd4;
   localparam logic [2:0] ST_PUSH   = 3'd5;

   logic [2:0]         state_ff, state_in;
   logic [OP_W-1:0]    op_ff, op_in;
   logic [STAMP_W-1:0] now_ff, now_in;
   logic [ENTRY_W-1:0] entry_ff, entry_in;
   logic [SW-1:0]      start_slot_ff, start_slot_in;
   logic [CNT_W-1:0]   fill_count_ff, fill_count_in;
   logic [SW-1:0]      slot_ff, slot_in;
   logic [CNT_W-1:0]   walk_ff, walk_in;
   logic [CNT_W-1:0]   marked_ff, marked_in;
   logic               status_ff, status_in;
   logic [STAMP_W-1:0] age_ff, age_in;
   logic               rsp_tvalid_ff, rsp_tvalid_in;
   rsp_type            rsp_data_ff, rsp_data_in;
   logic               rsp_status_ff, rsp_status_in;
   logic [CNT_W-1:0]   capacity_ff, capacity_in;
   logic [STAMP_W-1:0] max_age_ff, max_age_in;
   logic [STAMP_W-1:0] marker_ff, marker_in;

   logic [STAMP_W-1:0] stamp_mem [DEPTH];
   logic [STAMP_W-1:0] rd_data_ff;
   logic               mem_we, mem_re;
   logic [SW-1:0]      mem_waddr, mem_raddr;
   logic [STAMP_W-1:0] mem_wdata;

   logic [CNT_W-1:0]   cap_eff, cap_m1, live;
   logic [SUM_W-1:0]   cap_ext, start_ext, sum, sum_red;
   logic [CNT_W-1:0]   base;
   logic               div_start, div_done;
   logic [CNT_W-1:0]   div_rem;
   logic               is_marker, saturated;
   logic [STAMP_W-1:0] diff, age;
   logic               req_accept, csr_write;
   req_type            req_beat;

   assign req_accept = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign req_beat   = req_type'(req_tdata[$bits(req_type)-1:0]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_comb begin
      if (capacity_ff == '0) begin
         cap_eff = CNT_W'(1);
      end else if (32'(capacity_ff) > DEPTH_L) begin
         cap_eff = CNT_W'(DEPTH);
      end else begin
         cap_eff = capacity_ff;
      end
   end

   assign cap_m1    = cap_eff - 1'b1;
   assign live      = (fill_count_ff < cap_eff) ? fill_count_ff : cap_eff;
   assign cap_ext   = SUM_W'(cap_eff);
   assign start_ext = SUM_W'(start_slot_ff);
   assign base      = (op_ff == OP_READ) ? CNT_W'(entry_ff) : live - 1'b1;
   assign sum       = SUM_W'(base) + start_ext;
   assign sum_red   = (sum >= cap_ext) ? sum - cap_ext : sum;

   assign is_marker = (rd_data_ff == marker_ff);
   assign diff      = now_ff - rd_data_ff;
   assign saturated = is_marker || (diff >= max_age_ff);
   assign age       = saturated ? max_age_ff : diff;

   ahri_rem #(
      .NUM_W (SUM_W),
      .DEN_W (CNT_W)
   ) u_rem (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (sum),
      .den   (cap_eff),
      .done  (div_done),
      .rem   (div_rem)
   );

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      now_in        = now_ff;
      entry_in      = entry_ff;
      start_slot_in = start_slot_ff;
      fill_count_in = fill_count_ff;
      slot_in       = slot_ff;
      walk_in       = walk_ff;
      marked_in     = marked_ff;
      status_in     = status_ff;
      age_in        = age_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      mem_waddr     = slot_ff;
      mem_raddr     = slot_ff;
      mem_wdata     = marker_ff;
      div_start     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               op_in    = req_tuser;
               now_in   = req_beat.now;
               entry_in = req_beat.entry_number;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            status_in = 1'b0;
            age_in    = '0;
            marked_in = '0;
            slot_in   = '0;
            walk_in   = live - 1'b1;
            state_in  = ST_PUSH;
            case (op_ff)
               OP_ADD: begin
                  if (start_slot_ff == '0 || start_ext >= cap_ext) begin
                     start_slot_in = SW'(cap_m1);
                  end else begin
                     start_slot_in = start_slot_ff - 1'b1;
                  end
                  fill_count_in = (fill_count_ff >= cap_eff) ? cap_eff
                                                             : fill_count_ff + 1'b1;
                  slot_in   = start_slot_in;
                  mem_we    = 1'b1;
                  mem_waddr = start_slot_in;
                  mem_wdata = (now_ff == marker_ff) ? now_ff - 1'b1 : now_ff;
               end
               OP_CLEAR: begin
                  start_slot_in = '0;
                  fill_count_in = '0;
               end
               default: begin
                  if (op_ff == OP_READ && CNT_W'(entry_ff) >= live) begin
                     status_in = 1'b1;
                  end else if (op_ff == OP_SWEEP && live == '0) begin
                     state_in = ST_PUSH;
                  end else if (start_ext < cap_ext) begin
                     slot_in   = SW'(sum_red);
                     mem_re    = 1'b1;
                     mem_raddr = SW'(sum_red);
                     state_in  = ST_EVAL;
                  end else begin
                     div_start = 1'b1;
                     state_in  = ST_DIV;
                  end
               end
            endcase
         end
         ST_DIV: begin
            if (div_done) begin
               slot_in  = SW'(div_rem);
               state_in = ST_RD;
            end
         end
         ST_RD: begin
            mem_re   = 1'b1;
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (op_ff == OP_READ) begin
               age_in   = age;
               state_in = ST_PUSH;
            end else if (!saturated) begin
               state_in = ST_PUSH;
            end else begin
               mem_we = 1'b1;
               if (!is_marker) begin
                  marked_in = marked_ff + 1'b1;
               end
               if (walk_ff == '0) begin
                  state_in = ST_PUSH;
               end else begin
                  walk_in   = walk_ff - 1'b1;
                  slot_in   = (slot_ff == '0) ? SW'(cap_m1) : slot_ff - 1'b1;
                  mem_re    = 1'b1;
                  mem_raddr = slot_in;
               end
            end
         end
         ST_PUSH: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in            = 1'b1;
               rsp_status_in            = status_ff;
               rsp_data_in.slot_index   = (op_ff == OP_ADD || (op_ff == OP_READ && !status_ff))
                                          ? SLOT_OUT_W'(slot_ff) : '0;
               rsp_data_in.entry_age    = age_ff;
               rsp_data_in.entry_count  = fill_count_ff;
               rsp_data_in.marked_count = marked_ff;
               state_in                 = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      capacity_in = capacity_ff;
      max_age_in  = max_age_ff;
      marker_in   = marker_ff;
      if (csr_write) begin
         unique case (csr_paddr[3:2])
            REG_CAPACITY: capacity_in = csr_pwdata[CNT_W-1:0];
            REG_MAX_AGE:  max_age_in  = csr_pwdata;
            REG_MARKER:   marker_in   = csr_pwdata;
            default:      capacity_in = capacity_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_CAPACITY: csr_prdata = CSR_DATA_W'(capacity_ff);
         REG_MAX_AGE:  csr_prdata = max_age_ff;
         REG_MARKER:   csr_prdata = marker_ff;
         default:      csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         start_slot_ff <= '0;
         fill_count_ff <= '0;
         rsp_tvalid_ff <= 1'b0;
         capacity_ff   <= CAPACITY_RESET;
         max_age_ff    <= MAX_AGE_RESET;
         marker_ff     <= MARKER_RESET;
      end else begin
         state_ff      <= state_in;
         start_slot_ff <= start_slot_in;
         fill_count_ff <= fill_count_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         capacity_ff   <= capacity_in;
         max_age_ff    <= max_age_in;
         marker_ff     <= marker_in;
      end
      op_ff         <= op_in;
      now_ff        <= now_in;
      entry_ff      <= entry_in;
      slot_ff       <= slot_in;
      walk_ff       <= walk_in;
      marked_ff     <= marked_in;
      status_ff     <= status_in;
      age_ff        <= age_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         stamp_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= stamp_mem[mem_raddr];
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_data_ff);
   assign rsp_tuser  = rsp_status_ff;

   `AHRI_ASSERT_IMPLY(a_write_only_when_busy, clock, reset, mem_we,
                      state_ff == ST_DECODE || state_ff == ST_EVAL)
   `AHRI_ASSERT_IMPLY(a_eval_slot_in_ring, clock, reset, state_ff == ST_EVAL,
                      SUM_W'(slot_ff) < cap_ext)
   `AHRI_ASSERT_NEXT(a_add_start_in_ring, clock, reset, state_ff == ST_DECODE && op_ff == OP_ADD,
                     start_ext < cap_ext && fill_count_ff <= cap_eff)

endmodule
`default_nettype wire
